// ===== rtl/buffer_pool_frame_manager_macros.svh =====
// Assertion macros for the buffer pool frame manager checker.
// Depends on nothing; included by the checker file.
`ifndef BUFFER_POOL_FRAME_MANAGER_MACROS_SVH
`define BUFFER_POOL_FRAME_MANAGER_MACROS_SVH

// Same-cycle implication under reset.
`define BPFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buffer pool frame manager check failed");

// Next-cycle implication under reset.
`define BPFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buffer pool frame manager check failed");

`endif

// ===== rtl/bpfm_pkg.sv =====
// Package for the buffer pool frame manager: sizes, codes and state type.
// Used by the top level by scoped names; depends on nothing.
`default_nettype none

package bpfm_pkg;

  localparam int unsigned FRAMES = 16;
  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned PAGE_W = 24;
  localparam int unsigned PIN_W = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam logic [STAMP_W-1:0] TIMER_LIMIT = 32'd32000;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  localparam logic [2:0] KIND_PIN = 3'd0;
  localparam logic [2:0] KIND_UNPIN = 3'd1;
  localparam logic [2:0] KIND_DIRTY = 3'd2;
  localparam logic [2:0] KIND_FORCE = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;
  localparam logic [2:0] KIND_SHUT = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NOT_PINNED = 3'd2;
  localparam logic [2:0] ST_NO_FRAME = 3'd3;
  localparam logic [2:0] ST_SHUT_REFUSED = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_LOAD,
    S_FLUSH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/buffer_pool_frame_manager.sv =====
// Buffer pool frame manager top level: frame table, scan sequencer, result register.
// Depends on bpfm_pkg.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  kind_i, page_num_i
// out       output     out_valid_o/out_ready_i status, frame, write-back, read, counts, last
// cfg       input      cfg_we_i               cfg_wdata_i (LRU mode)
//
// An item is accepted while the sequencer is idle; pin, unpin, dirty, force and shutdown then scan one frame per cycle.
// Flush walks the frames once, and shutdown scans and then walks them, one frame per cycle while the output is free.
// Reset empties all frames and clears the timer and the counters.
// A stalled output holds the sequencer until the result is taken.
`default_nettype none

module buffer_pool_frame_manager (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [2:0]                        kind_i,
  input  wire logic [bpfm_pkg::PAGE_W-1:0]       page_num_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [2:0]                        status_o,
  output      logic [3:0]                        frame_o,
  output      logic                              write_back_o,
  output      logic [bpfm_pkg::PAGE_W-1:0]       write_page_o,
  output      logic                              read_request_o,
  output      logic [bpfm_pkg::CNT_W-1:0]        read_count_o,
  output      logic [bpfm_pkg::CNT_W-1:0]        write_count_o,
  output      logic                              last_o
);

  localparam int unsigned N = bpfm_pkg::FRAMES;
  localparam int unsigned IW = bpfm_pkg::IDX_W;

  bpfm_pkg::state_e state_q, state_d;
  logic lru_q;

  logic                           valid_q [N];
  logic                           valid_d [N];
  logic                           dirty_q [N];
  logic                           dirty_d [N];
  logic [bpfm_pkg::PIN_W-1:0]     pin_q   [N];
  logic [bpfm_pkg::PIN_W-1:0]     pin_d   [N];
  logic [bpfm_pkg::STAMP_W-1:0]   stamp_q [N];
  logic [bpfm_pkg::STAMP_W-1:0]   stamp_d [N];
  logic [bpfm_pkg::PAGE_W-1:0]    page_mem_q [N];
  logic [bpfm_pkg::PAGE_W-1:0]    page_rd_q;
  logic                           page_we;
  logic [IW-1:0]                  page_wa;

  logic [bpfm_pkg::STAMP_W-1:0]   timer_q, timer_d;
  logic [bpfm_pkg::CNT_W-1:0]     reads_q, reads_d, writes_q, writes_d;

  logic [2:0]                     kind_q, kind_d;
  logic [bpfm_pkg::PAGE_W-1:0]    pg_q, pg_d;
  logic [IW-1:0]                  ptr_q, ptr_d;
  logic                           hit_q, hit_d, free_q, free_d, vic_q, vic_d;
  logic                           pinned_q, pinned_d, emitted_q, emitted_d;
  logic [IW-1:0]                  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [IW-1:0]                  vic_idx_q, vic_idx_d, tgt_q, tgt_d;
  logic [bpfm_pkg::PIN_W-1:0]     hit_pin_q, hit_pin_d;
  logic                           vic_dirty_q, vic_dirty_d;
  logic [bpfm_pkg::PAGE_W-1:0]    vic_page_q, vic_page_d;
  logic [bpfm_pkg::STAMP_W-1:0]   best_q, best_d;

  logic                           ov_q;
  logic [2:0]                     ost_q;
  logic [IW-1:0]                  ofr_q;
  logic                           owb_q, orr_q, olast_q;
  logic [bpfm_pkg::PAGE_W-1:0]    owp_q;
  logic [bpfm_pkg::CNT_W-1:0]     orc_q, owc_q;

  logic                           out_free, emit;
  logic [2:0]                     e_st;
  logic [IW-1:0]                  e_fr;
  logic                           e_wb, e_rr, e_last;
  logic [bpfm_pkg::PAGE_W-1:0]    e_wp;

  logic [N-1:0]                   fq;
  logic                           above;
  logic                           accept;

  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == bpfm_pkg::S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    above = 1'b0;
    for (int j = 0; j < N; j++) begin
      fq[j] = valid_q[j] && dirty_q[j] && (pin_q[j] == '0);
      if ((IW'(j) > ptr_q) && fq[j]) begin
        above = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    pin_d = pin_q;
    stamp_d = stamp_q;
    timer_d = timer_q;
    reads_d = reads_q;
    writes_d = writes_q;
    kind_d = kind_q;
    pg_d = pg_q;
    ptr_d = ptr_q;
    hit_d = hit_q;
    free_d = free_q;
    vic_d = vic_q;
    pinned_d = pinned_q;
    emitted_d = emitted_q;
    hit_idx_d = hit_idx_q;
    free_idx_d = free_idx_q;
    vic_idx_d = vic_idx_q;
    tgt_d = tgt_q;
    hit_pin_d = hit_pin_q;
    vic_dirty_d = vic_dirty_q;
    vic_page_d = vic_page_q;
    best_d = best_q;
    page_we = 1'b0;
    page_wa = tgt_q;
    emit = 1'b0;
    e_st = bpfm_pkg::ST_OK;
    e_fr = '0;
    e_wb = 1'b0;
    e_wp = '0;
    e_rr = 1'b0;
    e_last = 1'b1;

    unique case (state_q)
      bpfm_pkg::S_IDLE: begin
        if (accept) begin
          kind_d = kind_i;
          pg_d = page_num_i;
          ptr_d = '0;
          hit_d = 1'b0;
          free_d = 1'b0;
          vic_d = 1'b0;
          pinned_d = 1'b0;
          emitted_d = 1'b0;
          best_d = timer_q;
          if (kind_i == bpfm_pkg::KIND_FLUSH) begin
            state_d = bpfm_pkg::S_FLUSH;
          end else if (kind_i <= bpfm_pkg::KIND_SHUT) begin
            state_d = bpfm_pkg::S_SCAN;
          end
        end
      end
      bpfm_pkg::S_SCAN: begin
        if (!hit_q && valid_q[ptr_q] && (page_rd_q == pg_q)) begin
          hit_d = 1'b1;
          hit_idx_d = ptr_q;
          hit_pin_d = pin_q[ptr_q];
        end
        if (!free_q && !valid_q[ptr_q]) begin
          free_d = 1'b1;
          free_idx_d = ptr_q;
        end
        if ((pin_q[ptr_q] == '0) && (stamp_q[ptr_q] <= best_q)) begin
          vic_d = 1'b1;
          vic_idx_d = ptr_q;
          best_d = stamp_q[ptr_q];
          vic_dirty_d = dirty_q[ptr_q];
          vic_page_d = page_rd_q;
        end
        if (valid_q[ptr_q] && (pin_q[ptr_q] != '0)) begin
          pinned_d = 1'b1;
        end
        if (ptr_q == IW'(N - 1)) begin
          state_d = bpfm_pkg::S_ACT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      bpfm_pkg::S_ACT: begin
        if (out_free) begin
          state_d = bpfm_pkg::S_IDLE;
          unique case (kind_q)
            bpfm_pkg::KIND_PIN: begin
              if (hit_q) begin
                emit = 1'b1;
                e_fr = hit_idx_q;
                if (hit_pin_q != bpfm_pkg::PIN_MAX) begin
                  pin_d[hit_idx_q] = hit_pin_q + 1'b1;
                end
                if (lru_q) begin
                  stamp_d[hit_idx_q] = timer_q;
                  timer_d = timer_q + 1'b1;
                end
              end else if (free_q) begin
                tgt_d = free_idx_q;
                state_d = bpfm_pkg::S_LOAD;
              end else begin
                if (timer_q > bpfm_pkg::TIMER_LIMIT) begin
                  timer_d = '0;
                  for (int j = 0; j < N; j++) begin
                    stamp_d[j] = '0;
                  end
                end
                if (!vic_q) begin
                  emit = 1'b1;
                  e_st = bpfm_pkg::ST_NO_FRAME;
                end else begin
                  tgt_d = vic_idx_q;
                  state_d = bpfm_pkg::S_LOAD;
                  if (vic_dirty_q) begin
                    emit = 1'b1;
                    e_fr = vic_idx_q;
                    e_wb = 1'b1;
                    e_wp = vic_page_q;
                    e_last = 1'b0;
                    dirty_d[vic_idx_q] = 1'b0;
                    writes_d = writes_q + 1'b1;
                  end
                end
              end
            end
            bpfm_pkg::KIND_UNPIN: begin
              emit = 1'b1;
              if (!hit_q) begin
                e_st = bpfm_pkg::ST_NOT_FOUND;
              end else if (hit_pin_q == '0) begin
                e_st = bpfm_pkg::ST_NOT_PINNED;
                e_fr = hit_idx_q;
              end else begin
                e_fr = hit_idx_q;
                pin_d[hit_idx_q] = hit_pin_q - 1'b1;
              end
            end
            bpfm_pkg::KIND_DIRTY: begin
              emit = 1'b1;
              if (!hit_q) begin
                e_st = bpfm_pkg::ST_NOT_FOUND;
              end else begin
                e_fr = hit_idx_q;
                dirty_d[hit_idx_q] = 1'b1;
              end
            end
            bpfm_pkg::KIND_FORCE: begin
              emit = 1'b1;
              if (!hit_q) begin
                e_st = bpfm_pkg::ST_NOT_FOUND;
              end else begin
                e_fr = hit_idx_q;
                e_wb = 1'b1;
                e_wp = pg_q;
                dirty_d[hit_idx_q] = 1'b0;
                writes_d = writes_q + 1'b1;
              end
            end
            default: begin
              if (pinned_q) begin
                emit = 1'b1;
                e_st = bpfm_pkg::ST_SHUT_REFUSED;
              end else begin
                ptr_d = '0;
                state_d = bpfm_pkg::S_FLUSH;
              end
            end
          endcase
        end
      end
      bpfm_pkg::S_LOAD: begin
        if (out_free) begin
          emit = 1'b1;
          e_fr = tgt_q;
          e_rr = 1'b1;
          reads_d = reads_q + 1'b1;
          valid_d[tgt_q] = 1'b1;
          pin_d[tgt_q] = {{(bpfm_pkg::PIN_W-1){1'b0}}, 1'b1};
          dirty_d[tgt_q] = 1'b0;
          stamp_d[tgt_q] = timer_q;
          timer_d = timer_q + 1'b1;
          page_we = 1'b1;
          state_d = bpfm_pkg::S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          if (fq[ptr_q]) begin
            emit = 1'b1;
            e_fr = ptr_q;
            e_wb = 1'b1;
            e_wp = page_rd_q;
            e_last = !above;
            dirty_d[ptr_q] = 1'b0;
            writes_d = writes_q + 1'b1;
            emitted_d = 1'b1;
          end else if ((ptr_q == IW'(N - 1)) && !emitted_q) begin
            emit = 1'b1;
          end
          if (ptr_q == IW'(N - 1)) begin
            state_d = bpfm_pkg::S_IDLE;
            if (kind_q == bpfm_pkg::KIND_SHUT) begin
              timer_d = '0;
              for (int j = 0; j < N; j++) begin
                valid_d[j] = 1'b0;
                dirty_d[j] = 1'b0;
                pin_d[j] = '0;
                stamp_d[j] = '0;
              end
            end
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfm_pkg::S_IDLE;
      lru_q <= 1'b0;
      timer_q <= '0;
      reads_q <= '0;
      writes_q <= '0;
      ov_q <= 1'b0;
      for (int j = 0; j < N; j++) begin
        valid_q[j] <= 1'b0;
        dirty_q[j] <= 1'b0;
        pin_q[j] <= '0;
        stamp_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        lru_q <= cfg_wdata_i;
      end
      timer_q <= timer_d;
      reads_q <= reads_d;
      writes_q <= writes_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      pin_q <= pin_d;
      stamp_q <= stamp_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pg_q <= pg_d;
    ptr_q <= ptr_d;
    hit_q <= hit_d;
    free_q <= free_d;
    vic_q <= vic_d;
    pinned_q <= pinned_d;
    emitted_q <= emitted_d;
    hit_idx_q <= hit_idx_d;
    free_idx_q <= free_idx_d;
    vic_idx_q <= vic_idx_d;
    tgt_q <= tgt_d;
    hit_pin_q <= hit_pin_d;
    vic_dirty_q <= vic_dirty_d;
    vic_page_q <= vic_page_d;
    best_q <= best_d;
    if (page_we) begin
      page_mem_q[page_wa] <= pg_q;
    end
    page_rd_q <= page_mem_q[ptr_d];
    if (emit) begin
      ost_q <= e_st;
      ofr_q <= e_fr;
      owb_q <= e_wb;
      owp_q <= e_wp;
      orr_q <= e_rr;
      olast_q <= e_last;
      orc_q <= reads_d;
      owc_q <= writes_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = ost_q;
  assign frame_o = 4'(ofr_q);
  assign write_back_o = owb_q;
  assign write_page_o = owp_q;
  assign read_request_o = orr_q;
  assign read_count_o = orc_q;
  assign write_count_o = owc_q;
  assign last_o = olast_q;

endmodule

`default_nettype wire

// ===== rtl/bpfm_checker.sv =====
// Port-level checker for the buffer pool frame manager, bound to the top level.
// Depends on buffer_pool_frame_manager_macros.svh and bpfm_pkg.
`default_nettype none
`include "buffer_pool_frame_manager_macros.svh"

module bpfm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [2:0]                  kind_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [2:0]                  status_o,
  input wire logic                        write_back_o,
  input wire logic [bpfm_pkg::PAGE_W-1:0] write_page_o,
  input wire logic                        read_request_o,
  input wire logic                        last_o
);

  `BPFM_ASSERT_NEXT(out_hold_a, out_valid_o && !out_ready_i, out_valid_o)
  `BPFM_ASSERT_NEXT(busy_after_accept_a,
                    in_valid_i && in_ready_o && (kind_i <= bpfm_pkg::KIND_SHUT), !in_ready_o)
  `BPFM_ASSERT_NOW(clean_page_zero_a, out_valid_o && !write_back_o, write_page_o == '0)
  `BPFM_ASSERT_NOW(read_is_final_a, out_valid_o && read_request_o,
                   last_o && !write_back_o && (status_o == bpfm_pkg::ST_OK))

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .kind_i(kind_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o(status_o),
  .write_back_o(write_back_o),
  .write_page_o(write_page_o),
  .read_request_o(read_request_o),
  .last_o(last_o)
);

`default_nettype wire
